// File: hdl/rgbero_pkg.sv
// Shared types, constants and helper functions for the RGBA masked erosion stream core.
// No dependencies; the interfaces and the core import this package.
package rgbero_pkg;

  localparam int KMAX_DEF      = 7;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MASK_STRIDE   = 7;
  localparam int MASK_W        = 49;
  localparam int MAX_RUN       = 16;
  localparam int COL_LIMIT     = 1024;
  localparam int ROW_LIMIT     = 4096;

  localparam int PIX_W    = 32;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int KDIM_W   = 4;
  localparam int KREG_W   = 3;
  localparam int IW_W     = 11;
  localparam int IH_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 49;
  localparam int RUN_CNT_W  = 4;

  localparam logic [KREG_W-1:0] KH_RST   = 3'd3;
  localparam logic [KREG_W-1:0] KW_RST   = 3'd3;
  localparam logic [MASK_W-1:0] MASK_RST = 49'd115591;
  localparam logic [IW_W-1:0]   IW_RST   = 11'd1024;
  localparam logic [IH_W-1:0]   IH_RST   = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_HEIGHT = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_KERNEL_MASK   = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_IMAGE_HEIGHT  = 3'd4
  } cfg_reg_t;

  // Describes the results one input request causes.
  typedef struct packed {
    logic             has;
    logic             err;
    logic [ROW_W-1:0] rlo;
    logic [ROW_W-1:0] rhi;
    logic [COL_W-1:0] clo;
    logic [COL_W-1:0] chi;
  } run_t;

  // Bytewise minimum of two packed RGBA pixels.
  function automatic logic [PIX_W-1:0] min4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] m;
    for (int i = 0; i < 4; i++) begin
      m[i*8 +: 8] = (a[i*8 +: 8] < b[i*8 +: 8]) ? a[i*8 +: 8] : b[i*8 +: 8];
    end
    return m;
  endfunction

endpackage

// File: hdl/rgbero_ifs.sv
// Valid/ready channel interfaces for the input pixel and result streams.
// Depends on rgbero_pkg for field widths.
interface rgbero_in_if import rgbero_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_pixel;
  modport source (output valid, output in_pixel, input ready);
  modport sink   (input valid, input in_pixel, output ready);
endinterface

interface rgbero_out_if import rgbero_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             last_in_run;
  logic             size_error;
  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output last_in_run, output size_error, input ready);
  modport sink   (input valid, input out_pixel, input out_row, input out_col,
                  input last_in_run, input size_error, output ready);
endinterface

// File: hdl/rgbero_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module rgbero_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/rgbero_core_top.sv
// Channel      Dir  Payload                                              Handshake
// in_chan      in   in_pixel[31:0]                                       valid/ready
// out_chan     out  out_pixel, out_row, out_col, last_in_run, size_error valid/ready
// cfg_*        in   cfg_index[2:0], cfg_data[48:0]                       cfg_we, no wait
//
// An inner request is registered in stage 1, stage 2, stage 3 and the result generator.
// A request that causes a run of results holds intake until the single result generator
// has issued the last of them; otherwise one request is accepted every cycle unless a
// pending result waits on out_chan. Requests that cause no result produce nothing.
// Reset is synchronous, active low; it clears counters and valid bits, presets config.
// The line store and the window hold no reset and are meaningful once written.
// A stall on out_chan freezes the whole pipeline, including the RAM read ports.
// Depends on rgbero_pkg, rgbero_ifs and rgbero_ram.
module rgba_masked_erosion_stream_core import rgbero_pkg::*; #(
  parameter int KMAX      = KMAX_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rgbero_in_if.sink             in_chan,
  rgbero_out_if.source          out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW     = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int WMAX   = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;

  // Configuration registers.
  logic [KREG_W-1:0] kh_reg_r, kw_reg_r;
  logic [MASK_W-1:0] mask_r;
  logic [IW_W-1:0]   iw_reg_r;
  logic [IH_W-1:0]   ih_reg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_reg_r <= KH_RST;
      kw_reg_r <= KW_RST;
      mask_r   <= MASK_RST;
      iw_reg_r <= IW_RST;
      ih_reg_r <= IH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KERNEL_HEIGHT: kh_reg_r <= cfg_data[KREG_W-1:0];
        REG_KERNEL_WIDTH:  kw_reg_r <= cfg_data[KREG_W-1:0];
        REG_KERNEL_MASK:   mask_r   <= cfg_data[MASK_W-1:0];
        REG_IMAGE_WIDTH:   iw_reg_r <= cfg_data[IW_W-1:0];
        REG_IMAGE_HEIGHT:  ih_reg_r <= cfg_data[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping into their legal ranges.
  logic [KDIM_W-1:0] kh, kw, my, mx;
  logic [IW_W-1:0]   w;
  logic [IH_W-1:0]   h;
  logic              size_bad;

  always_comb begin
    if (kh_reg_r == '0) begin
      kh = KDIM_W'(1);
    end else if (KDIM_W'(kh_reg_r) > KDIM_W'(KMAX)) begin
      kh = KDIM_W'(KMAX);
    end else begin
      kh = KDIM_W'(kh_reg_r);
    end
    if (kw_reg_r == '0) begin
      kw = KDIM_W'(1);
    end else if (KDIM_W'(kw_reg_r) > KDIM_W'(KMAX)) begin
      kw = KDIM_W'(KMAX);
    end else begin
      kw = KDIM_W'(kw_reg_r);
    end
    if (iw_reg_r == '0) begin
      w = IW_W'(1);
    end else if (iw_reg_r > IW_W'(WMAX)) begin
      w = IW_W'(WMAX);
    end else begin
      w = iw_reg_r;
    end
    if (ih_reg_r == '0) begin
      h = IH_W'(1);
    end else if (ih_reg_r > IH_W'(ROW_LIMIT)) begin
      h = IH_W'(ROW_LIMIT);
    end else begin
      h = ih_reg_r;
    end
    my = kh >> 1;
    mx = kw >> 1;
    size_bad = (w < IW_W'(kw)) || (h < IH_W'(kh));
  end

  // Pipeline advance: everything moves unless the result generator still owes results.
  logic gen_busy_r, gen_last, adv, accept;

  assign in_chan.ready = adv;
  assign accept        = in_chan.valid && adv;

  // Raster counters and the line slot of the current row.
  logic [ROW_W-1:0] rc_r, rc_nxt, ir_cur;
  logic [COL_W-1:0] cc_r, cc_nxt, ic_cur;
  logic [SW-1:0]    slot_r, slot_nxt, slot_cur;
  logic             restart;

  always_comb begin
    restart  = ({1'b0, rc_r} >= h) || ({1'b0, cc_r} >= w);
    ir_cur   = restart ? '0 : rc_r;
    ic_cur   = restart ? '0 : cc_r;
    slot_cur = restart ? '0 : slot_r;
    rc_nxt   = rc_r;
    cc_nxt   = cc_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (({1'b0, ic_cur} + IW_W'(1)) >= w) begin
        cc_nxt = '0;
        if (({1'b0, ir_cur} + IH_W'(1)) >= h) begin
          rc_nxt   = '0;
          slot_nxt = '0;
        end else begin
          rc_nxt   = ir_cur + ROW_W'(1);
          slot_nxt = (slot_cur == SW'(KMAX - 1)) ? '0 : slot_cur + SW'(1);
        end
      end else begin
        cc_nxt = ic_cur + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= '0;
      cc_r   <= '0;
      slot_r <= '0;
    end else begin
      rc_r   <= rc_nxt;
      cc_r   <= cc_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Line store: one RAM per row slot. The new pixel is written to its own slot while
  // every slot is read at the same column; the own-slot read is replaced by the pixel.
  logic [ADDR_W-1:0] line_addr;
  logic [PIX_W-1:0]  line_rd [KMAX];

  assign line_addr = ADDR_W'(ic_cur);

  for (genvar gs = 0; gs < KMAX; gs++) begin : g_line
    rgbero_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (accept && (slot_cur == SW'(gs))),
      .waddr (line_addr),
      .wdata (in_chan.in_pixel),
      .re    (adv),
      .raddr (line_addr),
      .rdata (line_rd[gs])
    );
  end

  // Stage 1: request held alongside the RAM read data.
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [SW-1:0]    s1_slot_r;
  logic [ROW_W-1:0] s1_ir_r;
  logic [COL_W-1:0] s1_ic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_chan.in_pixel;
      s1_slot_r <= slot_cur;
      s1_ir_r   <= ir_cur;
      s1_ic_r   <= ic_cur;
    end
  end

  // Wraps a small sum into 0..KMAX-1; the sum is below three times KMAX.
  function automatic logic [5:0] wrap_k(input logic [5:0] t);
    logic [5:0] u;
    u = t;
    if (u >= 6'(KMAX)) u = u - 6'(KMAX);
    if (u >= 6'(KMAX)) u = u - 6'(KMAX);
    return u;
  endfunction

  // Tap enables per (age, slot) and the run this request causes.
  logic             en_nxt [KMAX][KMAX];
  run_t             run_nxt;

  always_comb begin
    logic [5:0]       y;
    logic [KDIM_W-1:0] x;
    logic [7:0]       bitn;
    logic [13:0]      row_sum, row_lim;
    logic [11:0]      col_sum, col_lim;
    logic             inner;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    for (int a = 0; a < KMAX; a++) begin
      for (int s = 0; s < KMAX; s++) begin
        y    = wrap_k(6'(s) + 6'(KMAX) - 6'(s1_slot_r) + 6'(kh) - 6'd1);
        x    = kw - KDIM_W'(1) - KDIM_W'(a);
        bitn = 8'(y) * 8'(MASK_STRIDE) + 8'(x);
        en_nxt[a][s] = (y < 6'(kh)) && (KDIM_W'(a) < kw) && (bitn < 8'(MASK_W)) &&
                       mask_r[bitn[5:0]];
      end
    end
    // The window's last pixel closes inner output (r, c).
    row_sum = 14'(s1_ir_r) + 14'(my) + 14'(my) + 14'd2;
    row_lim = 14'(h) + 14'(kh);
    col_sum = 12'(s1_ic_r) + 12'(mx) + 12'(mx) + 12'd2;
    col_lim = 12'(w) + 12'(kw);
    inner = (s1_ir_r >= ROW_W'(kh - KDIM_W'(1))) && (row_sum <= row_lim) &&
            (s1_ic_r >= COL_W'(kw - KDIM_W'(1))) && (col_sum <= col_lim);
    r = s1_ir_r - ROW_W'(kh - KDIM_W'(1) - my);
    c = s1_ic_r - COL_W'(kw - KDIM_W'(1) - mx);
    run_nxt.err = size_bad;
    run_nxt.has = size_bad || inner;
    if (size_bad) begin
      run_nxt.rlo = s1_ir_r;
      run_nxt.rhi = s1_ir_r;
      run_nxt.clo = s1_ic_r;
      run_nxt.chi = s1_ic_r;
    end else begin
      // Border outputs copy the nearest inner output, so edge outputs widen the run.
      run_nxt.rlo = (r == ROW_W'(my)) ? '0 : r;
      run_nxt.rhi = ({1'b0, r} == h - IH_W'(1) - IH_W'(my)) ? ROW_W'(h - IH_W'(1)) : r;
      run_nxt.clo = (c == COL_W'(mx)) ? '0 : c;
      run_nxt.chi = ({1'b0, c} == w - IW_W'(1) - IW_W'(mx)) ? COL_W'(w - IW_W'(1)) : c;
    end
  end

  // Stage 2: the window registers, indexed by column age and line slot.
  logic             s2_valid_r;
  logic [PIX_W-1:0] win_r [KMAX][KMAX];
  logic             s2_en_r [KMAX][KMAX];
  run_t             s2_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      for (int a = KMAX - 1; a > 0; a--) begin
        win_r[a] <= win_r[a-1];
      end
      for (int s = 0; s < KMAX; s++) begin
        win_r[0][s] <= (s1_slot_r == SW'(s)) ? s1_pix_r : line_rd[s];
      end
      s2_en_r  <= en_nxt;
      s2_run_r <= run_nxt;
    end
  end

  // Stage 3: masked minimum within each line slot.
  logic             s3_valid_r;
  logic [PIX_W-1:0] s3_rowmin_r [KMAX];
  logic [PIX_W-1:0] rowmin_nxt [KMAX];
  run_t             s3_run_r;

  always_comb begin
    for (int s = 0; s < KMAX; s++) begin
      rowmin_nxt[s] = '1;
      for (int a = 0; a < KMAX; a++) begin
        if (s2_en_r[a][s]) begin
          rowmin_nxt[s] = min4(rowmin_nxt[s], win_r[a][s]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      s3_rowmin_r <= rowmin_nxt;
      s3_run_r    <= s2_run_r;
    end
  end

  logic [PIX_W-1:0] erode_pix;

  always_comb begin
    erode_pix = '1;
    for (int s = 0; s < KMAX; s++) begin
      erode_pix = min4(erode_pix, s3_rowmin_r[s]);
    end
  end

  // Result generator: walks the run row-major, at most MAX_RUN results.
  logic                 gen_busy_nxt, gen_err_r, gen_load;
  logic [PIX_W-1:0]     gen_pix_r;
  logic [ROW_W-1:0]     gen_y_r, gen_y_nxt, gen_rhi_r;
  logic [COL_W-1:0]     gen_x_r, gen_x_nxt, gen_clo_r, gen_chi_r;
  logic [RUN_CNT_W-1:0] gen_cnt_r, gen_cnt_nxt;
  logic                 out_fire;

  assign gen_last = gen_err_r || ((gen_x_r == gen_chi_r) && (gen_y_r == gen_rhi_r)) ||
                    (gen_cnt_r == RUN_CNT_W'(MAX_RUN - 1));
  assign adv      = !gen_busy_r || (out_chan.ready && gen_last);
  assign gen_load = adv && s3_valid_r && s3_run_r.has;
  assign out_fire = gen_busy_r && out_chan.ready;

  always_comb begin
    gen_busy_nxt = adv ? gen_load : gen_busy_r;
    gen_x_nxt    = gen_x_r;
    gen_y_nxt    = gen_y_r;
    gen_cnt_nxt  = gen_cnt_r;
    if (gen_load) begin
      gen_x_nxt   = s3_run_r.clo;
      gen_y_nxt   = s3_run_r.rlo;
      gen_cnt_nxt = '0;
    end else if (out_fire && !gen_last) begin
      gen_cnt_nxt = gen_cnt_r + RUN_CNT_W'(1);
      if (gen_x_r == gen_chi_r) begin
        gen_x_nxt = gen_clo_r;
        gen_y_nxt = gen_y_r + ROW_W'(1);
      end else begin
        gen_x_nxt = gen_x_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_busy_r <= 1'b0;
    end else begin
      gen_busy_r <= gen_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_x_r   <= gen_x_nxt;
    gen_y_r   <= gen_y_nxt;
    gen_cnt_r <= gen_cnt_nxt;
    if (gen_load) begin
      gen_err_r <= s3_run_r.err;
      gen_pix_r <= s3_run_r.err ? '0 : erode_pix;
      gen_clo_r <= s3_run_r.clo;
      gen_chi_r <= s3_run_r.chi;
      gen_rhi_r <= s3_run_r.rhi;
    end
  end

  assign out_chan.valid       = gen_busy_r;
  assign out_chan.out_pixel   = gen_pix_r;
  assign out_chan.out_row     = gen_y_r;
  assign out_chan.out_col     = gen_x_r;
  assign out_chan.last_in_run = gen_last;
  assign out_chan.size_error  = gen_err_r;

  // An error request always yields exactly one result.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_busy_r && gen_err_r) |-> gen_last)
    else $error("size error result not marked last");

  // The run walk never leaves its bounds.
  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    gen_busy_r |-> ((gen_y_r <= gen_rhi_r) && (gen_x_r <= gen_chi_r) &&
                    (gen_x_r >= gen_clo_r)))
    else $error("result position outside its run");

  // A waiting result holds its position until taken.
  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_busy_r && !out_chan.ready) |=> (gen_busy_r && $stable(gen_x_r) && $stable(gen_y_r)))
    else $error("pending result changed while stalled");

  // A stalled pipeline keeps its queued request.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s3_valid_r) |=> s3_valid_r)
    else $error("queued request lost during stall");

endmodule
